// File: sv/vcve_pkg.sv
// ----------------------------------------------------------------------------
// vcve_pkg
// Shared types, constants and face tables for the voxel cube vertex emitter.
// ----------------------------------------------------------------------------
package vcve_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W     = 32;
    localparam int SIZE_W      = 31;
    localparam int COUNT_W     = 32;
    localparam int NORM_W      = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Cube geometry.
    localparam int FACES_PER_VOXEL = 6;
    localparam int VERTS_PER_FACE  = 6;
    localparam int FACE_W          = $clog2(FACES_PER_VOXEL);
    localparam int VERT_W          = $clog2(VERTS_PER_FACE);

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_VOXEL_SIZE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z   = CFG_INDEX_W'(3);

    // Normal component codes.
    localparam logic signed [NORM_W-1:0] NORM_ZERO = 2'sb00;
    localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sb01;
    localparam logic signed [NORM_W-1:0] NORM_NEG  = 2'sb11;

    // One classified voxel: the low and high plane of each axis, saturated.
    typedef struct packed {
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
        logic signed [COORD_W-1:0] z_lo;
        logic signed [COORD_W-1:0] z_hi;
        logic                      second;
    } t_voxel_job;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } t_normal;

    // Corner codes of a face, slot 0 in the low bits.
    // Corner code: bit 0 = x high side, bit 1 = y high side, bit 2 = z high side.
    function automatic logic [2:0] face_corner(input logic [FACE_W-1:0] face,
                                               input logic [1:0] slot);
        logic [11:0] row;
        case (face)
            3'd0:    row = {3'd3, 3'd2, 3'd0, 3'd1};  // -z
            3'd1:    row = {3'd7, 3'd6, 3'd2, 3'd3};  // +y
            3'd2:    row = {3'd7, 3'd3, 3'd1, 3'd5};  // +x
            3'd3:    row = {3'd2, 3'd6, 3'd4, 3'd0};  // -x
            3'd4:    row = {3'd1, 3'd0, 3'd4, 3'd5};  // -y
            3'd5:    row = {3'd6, 3'd7, 3'd5, 3'd4};  // +z
            default: row = '0;
        endcase
        return row[slot*3 +: 3];
    endfunction

    // Two triangles per face, over corners 0,1,2 and 0,2,3.
    function automatic logic [1:0] tri_slot(input logic [VERT_W-1:0] vert);
        logic [1:0] slot;
        case (vert)
            3'd0:    slot = 2'd0;
            3'd1:    slot = 2'd1;
            3'd2:    slot = 2'd2;
            3'd3:    slot = 2'd0;
            3'd4:    slot = 2'd2;
            3'd5:    slot = 2'd3;
            default: slot = 2'd0;
        endcase
        return slot;
    endfunction

    // Outward normal of each face.
    function automatic t_normal face_normal(input logic [FACE_W-1:0] face);
        t_normal n;
        n = '{x: NORM_ZERO, y: NORM_ZERO, z: NORM_ZERO};
        case (face)
            3'd0:    n.z = NORM_NEG;
            3'd1:    n.y = NORM_POS;
            3'd2:    n.x = NORM_POS;
            3'd3:    n.x = NORM_NEG;
            3'd4:    n.y = NORM_NEG;
            3'd5:    n.z = NORM_POS;
            default: n = '{x: NORM_ZERO, y: NORM_ZERO, z: NORM_ZERO};
        endcase
        return n;
    endfunction

endpackage

// File: sv/vcve_front.sv
// ----------------------------------------------------------------------------
// vcve_front
// Holds the configuration registers, accepts voxel transactions and computes
// the saturated low and high plane of each axis in a short pipeline.
// ----------------------------------------------------------------------------
module vcve_front #(
    parameter int INDEX_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes
    input  logic                                i_cfg_valid,
    input  logic [vcve_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [vcve_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Voxel input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [INDEX_BITS-1:0]               i_voxel_x,
    input  logic [INDEX_BITS-1:0]               i_voxel_y,
    input  logic [INDEX_BITS-1:0]               i_voxel_z,
    input  logic                                i_component_sel,
    // Classified job toward the queue
    output logic                                o_job_valid,
    input  logic                                i_job_ready,
    output vcve_pkg::t_voxel_job                o_job
);
    import vcve_pkg::*;

    localparam int PROD_W = SIZE_W + INDEX_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1) << FRAC_BITS;

    // Configuration registers.
    logic [SIZE_W-1:0]         r_voxel_size;
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic signed [COORD_W-1:0] r_origin_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_size <= SIZE_RESET;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_origin_z   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOXEL_SIZE: r_voxel_size <= i_cfg_data[SIZE_W-1:0];
                CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data;
                CFG_ORIGIN_Z:   r_origin_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage advances when the one after it has room.
    logic r_s1_valid;
    logic r_s2_valid;
    logic w_s2_adv;
    logic w_s1_adv;
    logic w_in_adv;

    assign w_s2_adv    = r_s2_valid && i_job_ready;
    assign w_s1_adv    = r_s1_valid && (!r_s2_valid || w_s2_adv);
    assign o_ready     = !r_s1_valid || w_s1_adv;
    assign w_in_adv    = i_valid && o_ready;
    assign o_job_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_s2_valid || w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Stage 1: size times index on each axis.
    logic [PROD_W-1:0] r_s1_prod_x;
    logic [PROD_W-1:0] r_s1_prod_y;
    logic [PROD_W-1:0] r_s1_prod_z;
    logic              r_s1_sel;

    always_ff @(posedge i_clk) begin
        if (w_in_adv) begin
            r_s1_prod_x <= PROD_W'(r_voxel_size) * PROD_W'(i_voxel_x);
            r_s1_prod_y <= PROD_W'(r_voxel_size) * PROD_W'(i_voxel_y);
            r_s1_prod_z <= PROD_W'(r_voxel_size) * PROD_W'(i_voxel_z);
            r_s1_sel    <= i_component_sel;
        end
    end

    // Stage 2: exact low and high sums with the origin.
    logic signed [SUM_W-1:0] w_size_ext;
    logic signed [SUM_W-1:0] n_lo_x, n_lo_y, n_lo_z;
    logic signed [SUM_W-1:0] n_hi_x, n_hi_y, n_hi_z;
    logic signed [SUM_W-1:0] r_s2_lo_x, r_s2_lo_y, r_s2_lo_z;
    logic signed [SUM_W-1:0] r_s2_hi_x, r_s2_hi_y, r_s2_hi_z;
    logic                    r_s2_sel;

    assign w_size_ext = {{(SUM_W-SIZE_W){1'b0}}, r_voxel_size};

    always_comb begin
        n_lo_x = {{(SUM_W-COORD_W){r_origin_x[COORD_W-1]}}, r_origin_x}
               + {{(SUM_W-PROD_W){1'b0}}, r_s1_prod_x};
        n_lo_y = {{(SUM_W-COORD_W){r_origin_y[COORD_W-1]}}, r_origin_y}
               + {{(SUM_W-PROD_W){1'b0}}, r_s1_prod_y};
        n_lo_z = {{(SUM_W-COORD_W){r_origin_z[COORD_W-1]}}, r_origin_z}
               + {{(SUM_W-PROD_W){1'b0}}, r_s1_prod_z};
        n_hi_x = n_lo_x + w_size_ext;
        n_hi_y = n_lo_y + w_size_ext;
        n_hi_z = n_lo_z + w_size_ext;
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_lo_x <= n_lo_x;
            r_s2_lo_y <= n_lo_y;
            r_s2_lo_z <= n_lo_z;
            r_s2_hi_x <= n_hi_x;
            r_s2_hi_y <= n_hi_y;
            r_s2_hi_z <= n_hi_z;
            r_s2_sel  <= r_s1_sel;
        end
    end

    // Clamp an exact sum to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] saturate(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-COORD_W:0] top;
        logic signed [COORD_W-1:0] res;
        top = v[SUM_W-1:COORD_W-1];
        if ((top == '0) || (top == '1)) begin
            res = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Job leaving the front, saturated on the way into the queue.
    always_comb begin
        o_job.x_lo   = saturate(r_s2_lo_x);
        o_job.x_hi   = saturate(r_s2_hi_x);
        o_job.y_lo   = saturate(r_s2_lo_y);
        o_job.y_hi   = saturate(r_s2_hi_y);
        o_job.z_lo   = saturate(r_s2_lo_z);
        o_job.z_hi   = saturate(r_s2_hi_z);
        o_job.second = r_s2_sel;
    end

endmodule

// File: sv/vcve_job_queue.sv
// ----------------------------------------------------------------------------
// vcve_job_queue
// Short first-in first-out queue of classified voxel jobs between the front
// and the vertex sequencer.
// ----------------------------------------------------------------------------
module vcve_job_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  vcve_pkg::t_voxel_job i_push_job,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output vcve_pkg::t_voxel_job o_pop_job
);
    import vcve_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_voxel_job       r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_fill != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_entry[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// File: sv/vcve_back.sv
// ----------------------------------------------------------------------------
// vcve_back
// Vertex sequencer: walks the six faces and six triangle corners of the job
// at the head of the queue and, unless stalled, loads one vertex per cycle
// into the output register and keeps the running vertex count per component.
// ----------------------------------------------------------------------------
module vcve_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Job from the queue
    input  logic                                i_job_valid,
    output logic                                o_job_pop,
    input  vcve_pkg::t_voxel_job                i_job,
    // Vertex output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_z,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_z,
    output logic [vcve_pkg::COUNT_W-1:0]        o_vertex_total,
    output logic                                o_last_vertex
);
    import vcve_pkg::*;

    logic [FACE_W-1:0]  r_face;
    logic [VERT_W-1:0]  r_vert;
    logic [COUNT_W-1:0] r_comp_count [2];
    logic               r_out_valid;
    logic               w_load;
    logic               w_face_end;
    logic               w_job_end;
    logic [2:0]         w_corner;
    t_normal            w_normal;
    logic [COUNT_W-1:0] n_count;

    // A vertex is loaded whenever a job is waiting and the output register is free or draining.
    assign w_load     = i_job_valid && (!r_out_valid || i_ready);
    assign w_face_end = (r_vert == VERT_W'(VERTS_PER_FACE - 1));
    assign w_job_end  = w_face_end && (r_face == FACE_W'(FACES_PER_VOXEL - 1));
    assign o_job_pop  = w_load && w_job_end;
    assign o_valid    = r_out_valid;

    assign w_corner = face_corner(r_face, tri_slot(r_vert));
    assign w_normal = face_normal(r_face);
    assign n_count  = r_comp_count[i_job.second] + 1'b1;

    // Face and corner counters, component counts and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face          <= '0;
            r_vert          <= '0;
            r_comp_count[0] <= '0;
            r_comp_count[1] <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_comp_count[i_job.second] <= n_count;
                if (w_face_end) begin
                    r_vert <= '0;
                    r_face <= w_job_end ? '0 : r_face + 1'b1;
                end else begin
                    r_vert <= r_vert + 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_pos_x        <= w_corner[0] ? i_job.x_hi : i_job.x_lo;
            o_pos_y        <= w_corner[1] ? i_job.y_hi : i_job.y_lo;
            o_pos_z        <= w_corner[2] ? i_job.z_hi : i_job.z_lo;
            o_normal_x     <= w_normal.x;
            o_normal_y     <= w_normal.y;
            o_normal_z     <= w_normal.z;
            o_vertex_total <= n_count;
            o_last_vertex  <= w_job_end;
        end
    end

endmodule

// File: sv/voxel_cube_vertex_emitter.sv
// ----------------------------------------------------------------------------
// voxel_cube_vertex_emitter
// For each voxel transaction, emits the 36 vertices of the voxel's cube.
// ----------------------------------------------------------------------------
// Each accepted voxel yields 36 vertex transactions (faces -z, +y, +x, -x,
// -y, +z, two triangles each), carrying position, face normal and the
// running vertex count of the selected component. The vertex sequencer
// produces one vertex per cycle while a job is queued and the output is not
// held off, and successive voxels follow with no gap. The front computes the
// plane positions in its product and sum stages and a two-entry job queue
// lets it take new voxels while the sequencer is still busy. Configuration
// writes are always taken, but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module voxel_cube_vertex_emitter #(
    parameter int INDEX_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vcve_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [vcve_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Voxel input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [INDEX_BITS-1:0]               i_voxel_x,
    input  logic [INDEX_BITS-1:0]               i_voxel_y,
    input  logic [INDEX_BITS-1:0]               i_voxel_z,
    input  logic                                i_component_sel,
    // Vertex output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [vcve_pkg::COORD_W-1:0] o_pos_z,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vcve_pkg::NORM_W-1:0]  o_normal_z,
    output logic [vcve_pkg::COUNT_W-1:0]        o_vertex_total,
    output logic                                o_last_vertex
);
    import vcve_pkg::*;

    logic       w_front_valid;
    logic       w_front_ready;
    t_voxel_job w_front_job;
    logic       w_queue_valid;
    logic       w_queue_pop;
    t_voxel_job w_queue_job;

    // Register writes never stall.
    assign o_cfg_ready = 1'b1;

    // Front: configuration and plane computation.
    vcve_front #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_voxel_x       (i_voxel_x),
        .i_voxel_y       (i_voxel_y),
        .i_voxel_z       (i_voxel_z),
        .i_component_sel (i_component_sel),
        .o_job_valid     (w_front_valid),
        .i_job_ready     (w_front_ready),
        .o_job           (w_front_job)
    );

    // Job queue between the two halves.
    vcve_job_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_job   (w_front_job),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_queue_pop),
        .o_pop_job    (w_queue_job)
    );

    // Back: vertex sequencer and output register.
    vcve_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_queue_valid),
        .o_job_pop      (w_queue_pop),
        .i_job          (w_queue_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_vertex_total (o_vertex_total),
        .o_last_vertex  (o_last_vertex)
    );

endmodule

// File: tb/sv/voxel_cube_vertex_emitter_test.sv
// ----------------------------------------------------------------------------
// voxel_cube_vertex_emitter_test
// Self-checking testbench for the voxel cube vertex emitter.
// ----------------------------------------------------------------------------
// A directed stimulus list runs first. It covers the default geometry, grid
// extremes, saturated planes, a zero edge length and writes to spare register
// indexes. Random phases with random register settings follow. Every accepted
// voxel is expanded by a local cube model into its 36 vertices, and each
// vertex transaction is compared field by field against the oldest vertex
// still due. Both handshakes idle at random, except during a calm stretch.
// ----------------------------------------------------------------------------
module voxel_cube_vertex_emitter_test;
    import vcve_pkg::*;

    localparam int IDX_W          = 10;
    localparam int VERTS_PER_CUBE = FACES_PER_VOXEL * VERTS_PER_FACE;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_VOXELS  = 320;
    localparam int SETTLE_CYCLES  = 8;

    // Register indexes that the block does not decode.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP   = '1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Corner code per face slot: bit 0 x high, bit 1 y high, bit 2 z high.
    localparam logic [2:0] CUBE_CORNERS [FACES_PER_VOXEL][4] = '{
        '{3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd3, 3'd2, 3'd6, 3'd7},
        '{3'd5, 3'd1, 3'd3, 3'd7},
        '{3'd0, 3'd4, 3'd6, 3'd2},
        '{3'd5, 3'd4, 3'd0, 3'd1},
        '{3'd4, 3'd5, 3'd7, 3'd6}
    };
    localparam logic [1:0] TRIANGLE_SLOTS [VERTS_PER_FACE] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3
    };
    localparam logic signed [NORM_W-1:0] CUBE_NORMALS [FACES_PER_VOXEL][3] = '{
        '{NORM_ZERO, NORM_ZERO, NORM_NEG},
        '{NORM_ZERO, NORM_POS,  NORM_ZERO},
        '{NORM_POS,  NORM_ZERO, NORM_ZERO},
        '{NORM_NEG,  NORM_ZERO, NORM_ZERO},
        '{NORM_ZERO, NORM_NEG,  NORM_ZERO},
        '{NORM_ZERO, NORM_ZERO, NORM_POS}
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic [COUNT_W-1:0]        vertex_total;
        logic                      last_vertex;
    } t_vertex;

    // One line of the directed list: a register write or a voxel, the latter
    // optionally with the first vertex position typed in.
    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [IDX_W-1:0]       vx;
        logic [IDX_W-1:0]       vy;
        logic [IDX_W-1:0]       vz;
        logic                   sel;
        bit                     typed;
        logic [COORD_W-1:0]     first_x;
        logic [COORD_W-1:0]     first_y;
        logic [COORD_W-1:0]     first_z;
    } t_step;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [IDX_W-1:0]              i_voxel_x = '0;
    logic [IDX_W-1:0]              i_voxel_y = '0;
    logic [IDX_W-1:0]              i_voxel_z = '0;
    logic                          i_component_sel = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [COORD_W-1:0]     o_pos_x;
    logic signed [COORD_W-1:0]     o_pos_y;
    logic signed [COORD_W-1:0]     o_pos_z;
    logic signed [NORM_W-1:0]      o_normal_x;
    logic signed [NORM_W-1:0]      o_normal_y;
    logic signed [NORM_W-1:0]      o_normal_z;
    logic [COUNT_W-1:0]            o_vertex_total;
    logic                          o_last_vertex;

    // Shadow of the block's registers and component counters.
    logic [SIZE_W-1:0]             edge_len = SIZE_W'(65536);
    logic signed [COORD_W-1:0]     corner_x = '0;
    logic signed [COORD_W-1:0]     corner_y = '0;
    logic signed [COORD_W-1:0]     corner_z = '0;
    logic [COUNT_W-1:0]            comp_vertices [2] = '{'0, '0};

    t_vertex                       vertices_due [$];
    t_step                         plan [$];
    int                            bad_vertices = 0;
    int                            cycle_count = 0;
    bit                            calm = 1'b0;

    voxel_cube_vertex_emitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_voxel_x       (i_voxel_x),
        .i_voxel_y       (i_voxel_y),
        .i_voxel_z       (i_voxel_z),
        .i_component_sel (i_component_sel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_normal_z      (o_normal_z),
        .o_vertex_total  (o_vertex_total),
        .o_last_vertex   (o_last_vertex)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Cycle budget guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One cube plane: origin + edge * index (+ edge on the high side), formed
    // exactly and then clamped to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] clamp_plane(
        input logic signed [COORD_W-1:0] origin,
        input logic [IDX_W-1:0]          index,
        input logic                      high_side
    );
        longint sum;
        longint step_len;
        step_len = {33'd0, edge_len};
        sum = longint'(origin) + step_len * longint'({54'd0, index});
        if (high_side) begin
            sum = sum + step_len;
        end
        if (sum > longint'(COORD_MAX)) begin
            return COORD_MAX;
        end
        if (sum < longint'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return sum[COORD_W-1:0];
    endfunction

    // Expand one voxel into its 36 vertices and advance the component count.
    task automatic expand_cube(
        input logic [IDX_W-1:0] vx,
        input logic [IDX_W-1:0] vy,
        input logic [IDX_W-1:0] vz,
        input logic             sel
    );
        logic signed [COORD_W-1:0] xs [2];
        logic signed [COORD_W-1:0] ys [2];
        logic signed [COORD_W-1:0] zs [2];
        logic [2:0]                corner;
        logic [COUNT_W-1:0]        count;
        t_vertex                   v;
        count = comp_vertices[sel];
        for (int s = 0; s < 2; s++) begin
            xs[s] = clamp_plane(corner_x, vx, s[0]);
            ys[s] = clamp_plane(corner_y, vy, s[0]);
            zs[s] = clamp_plane(corner_z, vz, s[0]);
        end
        for (int f = 0; f < FACES_PER_VOXEL; f++) begin
            for (int t = 0; t < VERTS_PER_FACE; t++) begin
                corner = CUBE_CORNERS[f][TRIANGLE_SLOTS[t]];
                count = count + 1'b1;
                v.pos_x        = xs[corner[0]];
                v.pos_y        = ys[corner[1]];
                v.pos_z        = zs[corner[2]];
                v.normal_x     = CUBE_NORMALS[f][0];
                v.normal_y     = CUBE_NORMALS[f][1];
                v.normal_z     = CUBE_NORMALS[f][2];
                v.vertex_total = count;
                v.last_vertex  = (f == FACES_PER_VOXEL - 1) && (t == VERTS_PER_FACE - 1);
                vertices_due.push_back(v);
            end
        end
        comp_vertices[sel] = count;
    endtask

    // Send one voxel transaction, with random gaps ahead of it outside a calm stretch.
    task automatic send_voxel(
        input logic [IDX_W-1:0] vx,
        input logic [IDX_W-1:0] vy,
        input logic [IDX_W-1:0] vz,
        input logic             sel
    );
        int gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(99) < 5) begin
                gap = $urandom_range(60, 1);
            end else begin
                while ($urandom_range(99) < 17) begin
                    gap++;
                end
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_voxel_x       <= vx;
        i_voxel_y       <= vy;
        i_voxel_z       <= vz;
        i_component_sel <= sel;
        do @(posedge i_clk); while (!o_ready);
        expand_cube(vx, vy, vz, sel);
    endtask

    // Hold off the voxel channel until every vertex due has come back.
    task automatic drain_vertices();
        i_valid <= 1'b0;
        while (vertices_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; the shadow copy follows on acceptance.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_VOXEL_SIZE: edge_len = data[SIZE_W-1:0];
            CFG_ORIGIN_X:   corner_x = data;
            CFG_ORIGIN_Y:   corner_y = data;
            CFG_ORIGIN_Z:   corner_z = data;
            default:        ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_step reg_step(input logic [CFG_INDEX_W-1:0] index,
                                       input logic [CFG_DATA_W-1:0] data);
        t_step s;
        s = '{default: '0};
        s.is_write  = 1'b1;
        s.reg_index = index;
        s.reg_data  = data;
        return s;
    endfunction

    function automatic t_step voxel_step(
        input logic [IDX_W-1:0]   vx,
        input logic [IDX_W-1:0]   vy,
        input logic [IDX_W-1:0]   vz,
        input logic               sel,
        input bit                 typed,
        input logic [COORD_W-1:0] fx,
        input logic [COORD_W-1:0] fy,
        input logic [COORD_W-1:0] fz
    );
        t_step s;
        s = '{default: '0};
        s.vx      = vx;
        s.vy      = vy;
        s.vz      = vz;
        s.sel     = sel;
        s.typed   = typed;
        s.first_x = fx;
        s.first_y = fy;
        s.first_z = fz;
        return s;
    endfunction

    // Vertex receiver: random back-pressure and the field-by-field check.
    always @(posedge i_clk) begin : vertex_check
        t_vertex want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 17);
            if (o_valid && i_ready) begin
                if (vertices_due.size() == 0) begin
                    $error("vertex transaction with no vertex due");
                    bad_vertices++;
                end else begin
                    want = vertices_due.pop_front();
                    if (o_pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
                        bad_vertices++;
                    end
                    if (o_pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
                        bad_vertices++;
                    end
                    if (o_pos_z !== want.pos_z) begin
                        $error("pos_z: expected %0d, got %0d", want.pos_z, o_pos_z);
                        bad_vertices++;
                    end
                    if (o_normal_x !== want.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", want.normal_x, o_normal_x);
                        bad_vertices++;
                    end
                    if (o_normal_y !== want.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", want.normal_y, o_normal_y);
                        bad_vertices++;
                    end
                    if (o_normal_z !== want.normal_z) begin
                        $error("normal_z: expected %0d, got %0d", want.normal_z, o_normal_z);
                        bad_vertices++;
                    end
                    if (o_vertex_total !== want.vertex_total) begin
                        $error("vertex_total: expected %0d, got %0d",
                               want.vertex_total, o_vertex_total);
                        bad_vertices++;
                    end
                    if (o_last_vertex !== want.last_vertex) begin
                        $error("last_vertex: expected %0d, got %0d",
                               want.last_vertex, o_last_vertex);
                        bad_vertices++;
                    end
                end
            end
        end
    end

    // Stimulus: directed list, then random phases, then the verdict.
    initial begin
        int                     sent;
        int                     phase;
        int                     phase_len;
        logic [CFG_DATA_W-1:0]  data;
        logic [IDX_W-1:0]       rv [3];

        // Default geometry: unit cubes at the grid origin and the far corner,
        // then alternating bit patterns on both components.
        plan.push_back(voxel_step(10'd0, 10'd0, 10'd0, 1'b0, 1,
                                  32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
        plan.push_back(voxel_step(10'd1023, 10'd1023, 10'd1023, 1'b1, 1,
                                  32'h0400_0000, 32'h03FF_0000, 32'h03FF_0000));
        plan.push_back(voxel_step(10'h155, 10'h2AA, 10'h155, 1'b0, 0, '0, '0, '0));
        plan.push_back(voxel_step(10'h2AA, 10'h155, 10'h2AA, 1'b1, 0, '0, '0, '0));
        // Largest edge with extreme origins: many planes saturate high. The top
        // data bit of the edge register is dropped.
        plan.push_back(reg_step(CFG_VOXEL_SIZE, 32'hFFFF_FFFF));
        plan.push_back(reg_step(CFG_ORIGIN_X, 32'h7FFF_FFFF));
        plan.push_back(reg_step(CFG_ORIGIN_Y, 32'h8000_0000));
        plan.push_back(reg_step(CFG_ORIGIN_Z, 32'h0000_0000));
        plan.push_back(voxel_step(10'd1023, 10'd1023, 10'd1023, 1'b0, 1,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        plan.push_back(voxel_step(10'd0, 10'd0, 10'd0, 1'b1, 1,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        plan.push_back(voxel_step(10'd1, 10'd1, 10'd1, 1'b0, 0, '0, '0, '0));
        // Zero edge: every corner sits on the origin. Spare indexes are ignored.
        plan.push_back(reg_step(CFG_VOXEL_SIZE, 32'h0000_0000));
        plan.push_back(reg_step(CFG_ORIGIN_X, 32'h8000_0000));
        plan.push_back(reg_step(CFG_ORIGIN_Y, 32'h7FFF_FFFF));
        plan.push_back(reg_step(CFG_ORIGIN_Z, 32'h1234_5678));
        plan.push_back(reg_step(CFG_SPARE, 32'hDEAD_BEEF));
        plan.push_back(reg_step(CFG_TOP, 32'hFFFF_FFFF));
        plan.push_back(voxel_step(10'd1023, 10'd0, 10'd512, 1'b1, 1,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678));
        plan.push_back(voxel_step(10'd0, 10'd1023, 10'd0, 1'b0, 1,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678));
        // Smallest nonzero edge at the lowest origin.
        plan.push_back(reg_step(CFG_VOXEL_SIZE, 32'h0000_0001));
        plan.push_back(reg_step(CFG_ORIGIN_X, 32'h8000_0000));
        plan.push_back(reg_step(CFG_ORIGIN_Y, 32'h8000_0000));
        plan.push_back(reg_step(CFG_ORIGIN_Z, 32'h8000_0000));
        plan.push_back(voxel_step(10'd0, 10'd0, 10'd0, 1'b1, 1,
                                  32'h8000_0001, 32'h8000_0000, 32'h8000_0000));
        plan.push_back(voxel_step(10'd1023, 10'd1023, 10'd1023, 1'b0, 0, '0, '0, '0));
        // Fractional edge with negative x and y origins, some planes crossing zero.
        plan.push_back(reg_step(CFG_VOXEL_SIZE, 32'h0003_8000));
        plan.push_back(reg_step(CFG_ORIGIN_X, 32'hFF9C_0000));
        plan.push_back(reg_step(CFG_ORIGIN_Y, 32'hFFFF_8000));
        plan.push_back(reg_step(CFG_ORIGIN_Z, 32'h0000_4000));
        plan.push_back(voxel_step(10'd28, 10'd0, 10'd300, 1'b0, 0, '0, '0, '0));
        plan.push_back(voxel_step(10'd29, 10'd1, 10'd700, 1'b1, 0, '0, '0, '0));
        plan.push_back(voxel_step(10'd512, 10'd511, 10'd3, 1'b1, 0, '0, '0, '0));

        // Synchronous reset before the directed list.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed list; registers change only once the block is idle.
        foreach (plan[n]) begin
            if (plan[n].is_write) begin
                if (vertices_due.size() != 0) begin
                    drain_vertices();
                end
                write_reg(plan[n].reg_index, plan[n].reg_data);
            end else begin
                send_voxel(plan[n].vx, plan[n].vy, plan[n].vz, plan[n].sel);
                if (plan[n].typed) begin
                    vertices_due[vertices_due.size() - VERTS_PER_CUBE].pos_x = plan[n].first_x;
                    vertices_due[vertices_due.size() - VERTS_PER_CUBE].pos_y = plan[n].first_y;
                    vertices_due[vertices_due.size() - VERTS_PER_CUBE].pos_z = plan[n].first_z;
                end
            end
        end

        // Random phases, each under a fresh random register setting.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_VOXELS) begin
            drain_vertices();
            calm = (phase == 2) || (phase == 3);
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(5))
                    0:       data = $urandom_range(32'h0010_0000, 1);
                    1:       data = $urandom();
                    2:       data = 32'h0000_0000;
                    3:       data = 32'h7FFF_FFFF;
                    default: data = $urandom_range(32'h0004_0000, 32'h0000_4000);
                endcase
                write_reg(CFG_VOXEL_SIZE, data);
            end
            for (int r = 1; r <= 3; r++) begin
                if ($urandom_range(99) < 70) begin
                    case ($urandom_range(5))
                        0:       data = $urandom();
                        1:       data = 32'h7FFF_FFFF;
                        2:       data = 32'h8000_0000;
                        3:       data = 32'h0000_0000;
                        default: data = 32'($signed($urandom_range(2000000, 0)) - 1000000);
                    endcase
                    write_reg(CFG_INDEX_W'(r), data);
                end
            end
            if ($urandom_range(99) < 15) begin
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE : CFG_TOP, $urandom());
            end
            phase_len = $urandom_range(40, 10);
            for (int k = 0; k < phase_len; k++) begin
                for (int a = 0; a < 3; a++) begin
                    case ($urandom_range(9))
                        0:       rv[a] = '0;
                        1:       rv[a] = '1;
                        default: rv[a] = IDX_W'($urandom());
                    endcase
                end
                send_voxel(rv[0], rv[1], rv[2], 1'($urandom()));
                sent++;
            end
            phase++;
        end

        // Let the last vertices out and watch for stragglers.
        calm = 1'b0;
        i_valid <= 1'b0;
        while (vertices_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (bad_vertices == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: voxel_cube_vertex_emitter.f
sv/vcve_pkg.sv
sv/vcve_front.sv
sv/vcve_job_queue.sv
sv/vcve_back.sv
sv/voxel_cube_vertex_emitter.sv
tb/sv/voxel_cube_vertex_emitter_test.sv
